/* design/tlmc_pkg.sv */
package tlmc_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int DUR_W = 8;
  localparam int LAMP_W = 5;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 3;

  typedef logic [LAMP_W-1:0] lamp_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [DUR_W-1:0] dur_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam int LAMP_RED = 0;
  localparam int LAMP_YELLOW = 1;
  localparam int LAMP_GREEN = 2;
  localparam int LAMP_STOP = 3;
  localparam int LAMP_GO = 4;

  localparam lamp_t LAMPS_RED_GO = lamp_t'((1 << LAMP_RED) | (1 << LAMP_GO));
  localparam lamp_t LAMPS_GREEN_STOP = lamp_t'((1 << LAMP_GREEN) | (1 << LAMP_STOP));
  localparam lamp_t LAMPS_YELLOW = lamp_t'(1 << LAMP_YELLOW);
  localparam lamp_t LAMPS_OFF = '0;

  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_EMERGENCY = 2'd1;
  localparam mode_t MODE_PEDESTRIAN = 2'd2;
  localparam mode_t MODE_MAINTENANCE = 2'd3;

  localparam reg_idx_t REG_NORMAL_RED = 3'd0;
  localparam reg_idx_t REG_NORMAL_GREEN = 3'd1;
  localparam reg_idx_t REG_EMERGENCY = 3'd2;
  localparam reg_idx_t REG_PED_WARN = 3'd3;
  localparam reg_idx_t REG_PED_WALK = 3'd4;
  localparam reg_idx_t REG_BLINK_HALF = 3'd5;

  localparam dur_t RST_NORMAL_RED = 8'd50;
  localparam dur_t RST_NORMAL_GREEN = 8'd50;
  localparam dur_t RST_EMERGENCY = 8'd100;
  localparam dur_t RST_PED_WARN = 8'd50;
  localparam dur_t RST_PED_WALK = 8'd100;
  localparam dur_t RST_BLINK_HALF = 8'd5;

endpackage

/* design/traffic_light_mode_controller.sv */
// Traffic light mode controller, one transaction per 100 ms tick.
// Input channel: item_valid / item_stall carry the button events seen in one
// tick (emergency_event, pedestrian_event, maintenance_press). Output
// channel: result_valid / result_stall carry the lamps and active_mode in
// force after that tick; every input transaction yields exactly one result.
// Durations are set through the APB port (six 8-bit registers at byte
// addresses 0x00..0x14); write them only while the block is idle.
// An accepted tick is held in the input register, and its result is loaded
// into the result register when it advances. Throughput: one tick per
// cycle while the receiver does not stall, set by the single registered
// update of the mode state.
// When the receiver stalls, the result register holds, the input register
// fills, and item_stall rises so no further tick is taken until the stall
// clears.
// Reset (rst, synchronous) restores the register defaults, clears the
// pending flags and maintenance, and enters normal mode with red and walk
// lamps, with no result pending.
module traffic_light_mode_controller #(
  parameter int COUNT_WIDTH = tlmc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         emergency_event,
  input  logic                         pedestrian_event,
  input  logic                         maintenance_press,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         red_lamp,
  output logic                         yellow_lamp,
  output logic                         green_lamp,
  output logic                         walk_stop,
  output logic                         walk_go,
  output logic [tlmc_pkg::MODE_W-1:0]  active_mode,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlmc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlmc_pkg::DATA_W-1:0]  pwdata,
  output logic [tlmc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import tlmc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  dur_t normal_red_ticks;
  dur_t normal_green_ticks;
  dur_t emergency_ticks;
  dur_t ped_warn_ticks;
  dur_t ped_walk_ticks;
  dur_t blink_half_ticks;

  logic stage_valid;
  logic emergency_q;
  logic pedestrian_q;
  logic maint_q;

  mode_t mode_reg;
  mode_t mode_next;
  logic phase_reg;
  logic phase_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic emergency_pending;
  logic emergency_pending_next;
  logic pedestrian_pending;
  logic pedestrian_pending_next;
  logic maintenance_on;
  logic maintenance_on_next;
  lamp_t lamp_reg;
  lamp_t lamp_next;

  logic advance;
  logic cfg_write;
  reg_idx_t cfg_idx;

  logic [COUNT_WIDTH-1:0] count_inc;
  dur_t length;
  logic done;
  logic choose;
  mode_t chosen_mode;
  lamp_t chosen_lamps;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_red_ticks <= RST_NORMAL_RED;
      normal_green_ticks <= RST_NORMAL_GREEN;
      emergency_ticks <= RST_EMERGENCY;
      ped_warn_ticks <= RST_PED_WARN;
      ped_walk_ticks <= RST_PED_WALK;
      blink_half_ticks <= RST_BLINK_HALF;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_NORMAL_RED:   normal_red_ticks <= pwdata[DUR_W-1:0];
        REG_NORMAL_GREEN: normal_green_ticks <= pwdata[DUR_W-1:0];
        REG_EMERGENCY:    emergency_ticks <= pwdata[DUR_W-1:0];
        REG_PED_WARN:     ped_warn_ticks <= pwdata[DUR_W-1:0];
        REG_PED_WALK:     ped_walk_ticks <= pwdata[DUR_W-1:0];
        REG_BLINK_HALF:   blink_half_ticks <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NORMAL_RED:   prdata = DATA_W'(normal_red_ticks);
      REG_NORMAL_GREEN: prdata = DATA_W'(normal_green_ticks);
      REG_EMERGENCY:    prdata = DATA_W'(emergency_ticks);
      REG_PED_WARN:     prdata = DATA_W'(ped_warn_ticks);
      REG_PED_WALK:     prdata = DATA_W'(ped_walk_ticks);
      REG_BLINK_HALF:   prdata = DATA_W'(blink_half_ticks);
      default:          prdata = '0;
    endcase
  end

  // Input register, then state/result register.
  assign advance = stage_valid && (!result_valid || !result_stall);
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      emergency_q <= emergency_event;
      pedestrian_q <= pedestrian_event;
      maint_q <= maintenance_press;
    end
  end

  always_comb begin
    emergency_pending_next = emergency_pending | emergency_q;
    pedestrian_pending_next = pedestrian_pending | pedestrian_q;
    maintenance_on_next = maintenance_on ^ maint_q;

    count_inc = (tick_count != COUNT_MAX) ? tick_count + 1'b1 : tick_count;
    case (mode_reg)
      MODE_NORMAL:     length = phase_reg ? normal_green_ticks : normal_red_ticks;
      MODE_EMERGENCY:  length = emergency_ticks;
      MODE_PEDESTRIAN: length = phase_reg ? ped_walk_ticks : ped_warn_ticks;
      default:         length = blink_half_ticks;
    endcase
    done = (CMP_W'(count_inc) >= CMP_W'(length)) || (count_inc == COUNT_MAX);

    mode_next = mode_reg;
    phase_next = phase_reg;
    tick_count_next = count_inc;
    lamp_next = lamp_reg;
    choose = 1'b0;

    case (mode_reg)
      MODE_NORMAL: begin
        if (emergency_pending_next || pedestrian_pending_next || maintenance_on_next) begin
          choose = 1'b1;
        end else if (done) begin
          if (!phase_reg) begin
            phase_next = 1'b1;
            tick_count_next = '0;
            lamp_next = LAMPS_GREEN_STOP;
          end else begin
            choose = 1'b1;
          end
        end
      end
      MODE_EMERGENCY: begin
        if (maintenance_on_next) begin
          choose = 1'b1;
        end else if (done) begin
          emergency_pending_next = 1'b0;
          choose = 1'b1;
        end
      end
      MODE_PEDESTRIAN: begin
        if (emergency_pending_next || maintenance_on_next) begin
          choose = 1'b1;
        end else if (done) begin
          if (!phase_reg) begin
            phase_next = 1'b1;
            tick_count_next = '0;
            lamp_next = LAMPS_RED_GO;
          end else begin
            pedestrian_pending_next = 1'b0;
            choose = 1'b1;
          end
        end
      end
      default: begin
        if (done) begin
          if (!phase_reg) begin
            phase_next = 1'b1;
            tick_count_next = '0;
            lamp_next = lamp_reg & ~LAMPS_YELLOW;
          end else begin
            choose = 1'b1;
          end
        end
      end
    endcase

    if (maintenance_on_next) begin
      chosen_mode = MODE_MAINTENANCE;
    end else if (emergency_pending_next) begin
      chosen_mode = MODE_EMERGENCY;
    end else if (pedestrian_pending_next) begin
      chosen_mode = MODE_PEDESTRIAN;
    end else begin
      chosen_mode = MODE_NORMAL;
    end
    case (chosen_mode)
      MODE_NORMAL:     chosen_lamps = LAMPS_RED_GO;
      MODE_EMERGENCY:  chosen_lamps = LAMPS_GREEN_STOP;
      MODE_PEDESTRIAN: chosen_lamps = lamp_reg | LAMPS_YELLOW;
      default:         chosen_lamps = LAMPS_YELLOW;
    endcase

    if (choose) begin
      mode_next = chosen_mode;
      phase_next = 1'b0;
      tick_count_next = '0;
      lamp_next = chosen_lamps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      mode_reg <= MODE_NORMAL;
      phase_reg <= 1'b0;
      tick_count <= '0;
      emergency_pending <= 1'b0;
      pedestrian_pending <= 1'b0;
      maintenance_on <= 1'b0;
      lamp_reg <= LAMPS_RED_GO;
    end else begin
      if (advance) begin
        result_valid <= 1'b1;
        mode_reg <= mode_next;
        phase_reg <= phase_next;
        tick_count <= tick_count_next;
        emergency_pending <= emergency_pending_next;
        pedestrian_pending <= pedestrian_pending_next;
        maintenance_on <= maintenance_on_next;
        lamp_reg <= lamp_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign red_lamp = lamp_reg[LAMP_RED];
  assign yellow_lamp = lamp_reg[LAMP_YELLOW];
  assign green_lamp = lamp_reg[LAMP_GREEN];
  assign walk_stop = lamp_reg[LAMP_STOP];
  assign walk_go = lamp_reg[LAMP_GO];
  assign active_mode = mode_reg;

  a_emergency_lamps: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_EMERGENCY |-> lamp_reg == LAMPS_GREEN_STOP)
    else $error("emergency mode with wrong lamps");

  a_normal_lamps: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_NORMAL |-> (lamp_reg == LAMPS_RED_GO || lamp_reg == LAMPS_GREEN_STOP))
    else $error("normal mode with wrong lamps");

  a_maint_lamps: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_MAINTENANCE |-> (lamp_reg == LAMPS_YELLOW || lamp_reg == LAMPS_OFF))
    else $error("maintenance mode with wrong lamps");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_valid))
    else $error("result without a registered tick");

endmodule
